FILE: rtl/box_blur_3x3_replicate_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur unit
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_REPLICATE_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_REPLICATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge out of reset.
`define BB3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Antecedent this edge implies consequent at the next edge.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB3_ASSERT(label, prop, msg)
`define BB3_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, register codes and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);   // column index
  localparam int ROW_W = $clog2(MAX_HEIGHT);  // row index
  localparam int WID_W = 11;                  // image_width register
  localparam int HGT_W = 13;                  // image_height register
  localparam int CFG_W = 13;                  // widest register
  localparam int CFG_IDX_W = 2;

  localparam int CS_W   = 10;                 // column sum, 3 x 255
  localparam int SUM_W  = 12;                 // window sum, 9 x 255
  localparam int LINE_W = 2 * PIX_W;          // {older, newer} line entry

  // floor(s / 9) = (s * 7282) >> 16, exact for s < 32768
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_MUL_W = 13;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = SUM_W + DIV9_MUL_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH   = 2'd3;

  localparam logic [WID_W-1:0] RST_IMAGE_WIDTH  = 11'd512;
  localparam logic [HGT_W-1:0] RST_IMAGE_HEIGHT = 13'd512;
  localparam logic [PIX_W-1:0] RST_CLAMP_LOW    = 8'd0;
  localparam logic [PIX_W-1:0] RST_CLAMP_HIGH   = 8'd255;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // One queue entry: optional seed of the column window, optional push of a
  // new column sum with a result, optional duplicated right column.
  typedef struct packed {
    logic            seed;
    logic            push;
    logic            dup;
    logic            image_end;
    logic [CS_W-1:0] seed_cs;
    logic [CS_W-1:0] cs;
  } bb3_entry_t;

endpackage

`default_nettype wire

FILE: rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// Short FIFO of work entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_replicate_unit_assert.svh"

module bb3_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bb3_pkg::bb3_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output bb3_pkg::bb3_entry_t entry_o
);
  import bb3_pkg::*;

  bb3_entry_t        slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign entry_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  `BB3_ASSERT(a_q_no_overrun, !(push_i && full_o) && !(pop_i && !valid_o), "queue over/underrun")
  `BB3_ASSERT_NEXT(a_q_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count")

endmodule

`default_nettype wire

FILE: rtl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Accepts beats, tracks row/column/drain position, reads and updates the
// line store and forms column sums for the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_replicate_unit_assert.svh"

module bb3_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [bb3_pkg::PIX_W-1:0]  pixel_in_i,
  input  logic [bb3_pkg::WID_W-1:0]  image_width_i,
  input  logic [bb3_pkg::HGT_W-1:0]  image_height_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output bb3_pkg::bb3_entry_t        q_entry_o
);
  import bb3_pkg::*;

  localparam logic [WID_W-1:0] W_MIN = WID_W'(2);
  localparam logic [WID_W-1:0] W_MAX = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] H_MIN = HGT_W'(2);
  localparam logic [HGT_W-1:0] H_MAX = HGT_W'(MAX_HEIGHT);

  // position state
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] drain_q, drain_d;
  logic             draining_q, draining_d;

  // read stage
  logic              st_valid_q, st_valid_d;
  logic              st_drain_q, st_first_q, st_last_q;
  logic              st_row_ge1_q, st_row_ge2_q;
  logic [PIX_W-1:0]  st_px_q;
  logic [COL_W-1:0]  st_addr_q;
  logic              st_byp_q;
  logic [LINE_W-1:0] st_byp_data_q;
  logic [CS_W-1:0]   col0_cs_q;

  logic [WID_W-1:0]  eff_w;
  logic [HGT_W-1:0]  eff_h;
  logic [WID_W-1:0]  col_nx, drn_nx;
  logic [HGT_W-1:0]  row_nx;
  logic              pix_last, drn_last, row_last;
  logic [COL_W-1:0]  drn_raddr, raddr;
  logic              is_pix, acts, accept, go;
  logic              st_needs_push, st_go, wr_en, byp;
  logic [LINE_W-1:0] ram_rdata, rd, wr_data;
  logic [PIX_W-1:0]  older, newer, top;
  logic [CS_W-1:0]   pix_cs, drn_cs, col0_cs_d;

  // size registers clamped to the supported range
  always_comb begin
    if (image_width_i < W_MIN) begin
      eff_w = W_MIN;
    end else if (image_width_i > W_MAX) begin
      eff_w = W_MAX;
    end else begin
      eff_w = image_width_i;
    end
    if (image_height_i < H_MIN) begin
      eff_h = H_MIN;
    end else if (image_height_i > H_MAX) begin
      eff_h = H_MAX;
    end else begin
      eff_h = image_height_i;
    end
  end

  assign col_nx   = {1'b0, col_q} + WID_W'(1);
  assign drn_nx   = {1'b0, drain_q} + WID_W'(1);
  assign row_nx   = {1'b0, row_q} + HGT_W'(1);
  assign pix_last = (col_nx >= eff_w);
  assign drn_last = (drn_nx >= eff_w);
  assign row_last = (row_nx >= eff_h);

  // drain reads the right neighbor; at the row end it is the last column
  assign drn_raddr = drn_last ? COL_W'(eff_w - WID_W'(1)) : drn_nx[COL_W-1:0];

  assign is_pix = (cmd_i == CMD_PIXEL);
  assign acts   = is_pix ? !draining_q : draining_q;
  assign accept = in_valid_i && in_ready_o;
  assign go     = accept && acts;
  assign raddr  = is_pix ? col_q : drn_raddr;

  assign st_needs_push = st_valid_q && (st_drain_q || st_row_ge1_q);
  assign st_go         = st_valid_q && (!st_needs_push || !q_full_i);
  assign in_ready_o    = !st_valid_q || st_go;
  assign wr_en         = st_go && !st_drain_q;
  // the line entry written this cycle is the one read now
  assign byp           = wr_en && (st_addr_q == raddr);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    drain_d    = drain_q;
    draining_d = draining_q;
    if (go) begin
      if (is_pix) begin
        if (pix_last) begin
          col_d = '0;
          if (row_last) begin
            draining_d = 1'b1;
            drain_d    = '0;
          end else begin
            row_d = row_nx[ROW_W-1:0];
          end
        end else begin
          col_d = col_nx[COL_W-1:0];
        end
      end else begin
        if (drn_last) begin
          draining_d = 1'b0;
          row_d      = '0;
          col_d      = '0;
          drain_d    = '0;
        end else begin
          drain_d = drn_nx[COL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (in_ready_o) begin
      st_valid_d = go;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      drain_q    <= drain_d;
      draining_q <= draining_d;
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      st_drain_q    <= !is_pix;
      st_first_q    <= is_pix ? (col_q == '0) : (drain_q == '0);
      st_last_q     <= is_pix ? pix_last : drn_last;
      st_row_ge1_q  <= (row_q != '0);
      st_row_ge2_q  <= (row_q >= ROW_W'(2));
      st_px_q       <= pixel_in_i;
      st_addr_q     <= col_q;
      st_byp_q      <= byp;
      st_byp_data_q <= wr_data;
    end
    if (wr_en && st_first_q) begin
      col0_cs_q <= col0_cs_d;
    end
  end

  bb3_ram #(
    .Width(LINE_W),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(st_addr_q),
    .wdata_i(wr_data),
    .re_i   (go),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // entry layout {older row, newer row}
  assign rd    = st_byp_q ? st_byp_data_q : ram_rdata;
  assign older = rd[LINE_W-1:PIX_W];
  assign newer = rd[PIX_W-1:0];
  assign top   = st_row_ge2_q ? older : newer;

  assign wr_data   = {newer, st_px_q};
  assign pix_cs    = CS_W'(top) + CS_W'(newer) + CS_W'(st_px_q);
  // last row: rows H-2, H-1, H-1
  assign drn_cs    = CS_W'(older) + CS_W'({newer, 1'b0});
  // column 0 as the drain will see it
  assign col0_cs_d = CS_W'(newer) + CS_W'({st_px_q, 1'b0});

  assign q_push_o            = st_needs_push && !q_full_i;
  assign q_entry_o.seed      = st_first_q;
  assign q_entry_o.push      = st_drain_q || !st_first_q;
  assign q_entry_o.dup       = !st_drain_q && st_last_q;
  assign q_entry_o.image_end = st_drain_q && st_last_q;
  assign q_entry_o.seed_cs   = st_drain_q ? col0_cs_q : pix_cs;
  assign q_entry_o.cs        = st_drain_q ? drn_cs : pix_cs;

  `BB3_ASSERT(a_drain_col_zero, draining_q |-> (col_q == '0), "column not zero in drain")

endmodule

`default_nettype wire

FILE: rtl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Keeps the two newest column sums, forms window sums, divides by nine,
// clamps and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_replicate_unit_assert.svh"

module bb3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  bb3_pkg::bb3_entry_t       q_entry_i,
  output logic                      q_pop_o,
  input  logic [bb3_pkg::PIX_W-1:0] clamp_low_i,
  input  logic [bb3_pkg::PIX_W-1:0] clamp_high_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      run_last_o,
  output logic                      image_end_o
);
  import bb3_pkg::*;

  logic [CS_W-1:0]  win_a_q, win_a_d;   // column c-1
  logic [CS_W-1:0]  win_b_q, win_b_d;   // column c
  logic             phase_q, phase_d;   // second beat of a row end
  logic             s_valid_q, s_valid_d;
  logic [SUM_W-1:0] s_sum_q, s_sum_d;
  logic             s_last_q, s_last_d;
  logic             s_end_q, s_end_d;
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q;
  logic             run_last_q, image_end_q;

  logic             o_rdy, s_rdy, fire;
  logic [CS_W-1:0]  base_a, base_b;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0] quot, clamped;

  assign o_rdy = !out_valid_q || out_ready_i;
  assign s_rdy = !s_valid_q || o_rdy;
  assign fire  = q_valid_i && s_rdy;

  always_comb begin
    base_a    = q_entry_i.seed ? q_entry_i.seed_cs : win_a_q;
    base_b    = q_entry_i.seed ? q_entry_i.seed_cs : win_b_q;
    win_a_d   = win_a_q;
    win_b_d   = win_b_q;
    phase_d   = phase_q;
    s_valid_d = s_valid_q;
    s_sum_d   = s_sum_q;
    s_last_d  = s_last_q;
    s_end_d   = s_end_q;
    q_pop_o   = 1'b0;
    if (s_rdy) begin
      s_valid_d = 1'b0;
    end
    if (fire) begin
      if (phase_q) begin
        // replicated right border
        win_a_d   = win_b_q;
        s_sum_d   = SUM_W'(win_a_q) + SUM_W'(win_b_q) + SUM_W'(win_b_q);
        s_valid_d = 1'b1;
        s_last_d  = 1'b1;
        s_end_d   = 1'b0;
        phase_d   = 1'b0;
        q_pop_o   = 1'b1;
      end else if (q_entry_i.push) begin
        win_a_d   = base_b;
        win_b_d   = q_entry_i.cs;
        s_sum_d   = SUM_W'(base_a) + SUM_W'(base_b) + SUM_W'(q_entry_i.cs);
        s_valid_d = 1'b1;
        s_last_d  = !q_entry_i.dup;
        s_end_d   = q_entry_i.image_end;
        phase_d   = q_entry_i.dup;
        q_pop_o   = !q_entry_i.dup;
      end else begin
        win_a_d = base_a;
        win_b_d = base_b;
        q_pop_o = 1'b1;
      end
    end
  end

  // divide by nine, then clamp; the high-limit test comes first, so crossed limits give high or low
  assign prod = PROD_W'(s_sum_q) * PROD_W'(DIV9_MUL);
  assign quot = prod[DIV9_SHIFT +: PIX_W];

  always_comb begin
    if (quot > clamp_high_i) begin
      clamped = clamp_high_i;
    end else if (quot < clamp_low_i) begin
      clamped = clamp_low_i;
    end else begin
      clamped = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q     <= '0;
      win_b_q     <= '0;
      phase_q     <= 1'b0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_a_q   <= win_a_d;
      win_b_q   <= win_b_d;
      phase_q   <= phase_d;
      s_valid_q <= s_valid_d;
      if (o_rdy) begin
        out_valid_q <= s_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_sum_q  <= s_sum_d;
    s_last_q <= s_last_d;
    s_end_q  <= s_end_d;
    if (o_rdy && s_valid_q) begin
      pixel_q     <= clamped;
      run_last_q  <= s_last_q;
      image_end_q <= s_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign run_last_o  = run_last_q;
  assign image_end_o = image_end_q;

  `BB3_ASSERT(a_dup_head_held, phase_q |-> (q_valid_i && q_entry_i.push && q_entry_i.dup), "dup head lost")

endmodule

`default_nettype wire

FILE: rtl/box_blur_3x3_replicate_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_replicate_unit
// Streaming 3x3 mean filter with replicated borders for 8-bit grey images.
// ----------------------------------------------------------------------------
// - Input beats (in_valid_i/in_ready_o): pixels in raster order (cmd_i =
//   pixel), then W drain beats for the final row. Wrong-phase beats are
//   accepted and dropped.
// - Output beats (out_valid_o/out_ready_i): pixel (r, c) gives (r-1, c-1);
//   the last column also gives (r-1, W-1). run_last marks the last result of
//   an input beat, image_end the final pixel of the image.
// - Throughput: one beat per cycle into the 4-entry queue while the queue is
//   not full; column 0 only seeds the window in the back end and gives no
//   result, so over long images the back end, not the input, sets the pace.
// - Reset clears position and handshake state; the line store needs no init
//   pass, so beats are taken right after reset.
// - Output stall: the output register holds, the back end and then the queue
//   fill, and in_ready_o drops. cfg_we_i writes one register per cycle;
//   write only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_replicate_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [bb3_pkg::PIX_W-1:0]     pixel_in_i,
  // output beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          run_last_o,
  output logic                          image_end_o
);
  import bb3_pkg::*;

  logic [WID_W-1:0] image_width_q;
  logic [HGT_W-1:0] image_height_q;
  logic [PIX_W-1:0] clamp_low_q;
  logic [PIX_W-1:0] clamp_high_q;

  logic       q_push, q_full, q_pop, q_valid;
  bb3_entry_t q_in, q_out;

  // configuration registers, taken effect at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      clamp_low_q    <= RST_CLAMP_LOW;
      clamp_high_q   <= RST_CLAMP_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i[WID_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_data_i[HGT_W-1:0];
        end
        CFG_CLAMP_LOW: begin
          clamp_low_q <= cfg_data_i[PIX_W-1:0];
        end
        CFG_CLAMP_HIGH: begin
          clamp_high_q <= cfg_data_i[PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: position tracking, line store, column sums
  bb3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .pixel_in_i    (pixel_in_i),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  // decoupling queue
  bb3_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_out)
  );

  // back: window sum, divide by nine, clamp, output register
  bb3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .clamp_low_i (clamp_low_q),
    .clamp_high_i(clamp_high_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .run_last_o  (run_last_o),
    .image_end_o (image_end_o)
  );

endmodule

`default_nettype wire

FILE: verif/box_blur_3x3_replicate_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_replicate_unit_tb
// Self-checking bench for the streaming 3x3 mean filter: drives pixel and
// drain beats with random bursts and output stalls, predicts every filtered
// beat in a scoreboard and compares each output beat field by field.
// ----------------------------------------------------------------------------

module box_blur_3x3_replicate_unit_tb;

  import bb3_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned SQUEEZE_CYCLES = 400;      // long output hold-off
  localparam int unsigned RANDOM_BEATS   = 850;
  localparam int unsigned NO_RETUNE      = 32'hFFFF_FFFF;
  localparam int unsigned TIMEOUT_NS     = 8_000_000;
  localparam int unsigned MAX_REPORTS    = 40;

  // one filtered output beat
  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             run_last;
    logic             image_end;
  } blur_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the line stores, window and raster
  // position, turns each accepted input beat into the blurred beats it must
  // produce, and checks output beats against them in order.
  // --------------------------------------------------------------------------
  class blur_scoreboard;
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    logic [PIX_W-1:0] win [9];          // 3 columns x 3 rows, oldest first
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    int unsigned      drain_pos;
    bit               draining;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [PIX_W-1:0] low_lim;
    logic [PIX_W-1:0] high_lim;
    blur_result_t     expected_blur_q [$];
    int unsigned      errors;
    int unsigned      frames_done;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt     = 0;
      col_cnt     = 0;
      drain_pos   = 0;
      draining    = 1'b0;
      width_reg   = RST_IMAGE_WIDTH;
      height_reg  = RST_IMAGE_HEIGHT;
      low_lim     = RST_CLAMP_LOW;
      high_lim    = RST_CLAMP_HIGH;
      errors      = 0;
      frames_done = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[HGT_W-1:0];
        CFG_CLAMP_LOW:    low_lim    = data[PIX_W-1:0];
        CFG_CLAMP_HIGH:   high_lim   = data[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 2) return 2;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_blur_q.size();
    endfunction

    // floor(sum / 9), then clamp with the high limit tested before the low limit
    function logic [PIX_W-1:0] clamped_mean(int unsigned sum);
      int unsigned q;
      q = sum / 9;
      if (q > high_lim) q = high_lim;
      else if (q < low_lim) q = low_lim;
      return q[PIX_W-1:0];
    endfunction

    function void shift_col(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                            logic [PIX_W-1:0] bot);
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top;
      win[7] = mid;
      win[8] = bot;
    endfunction

    function int unsigned win_sum();
      int unsigned s;
      s = 0;
      foreach (win[i]) s += win[i];
      return s;
    endfunction

    function void push_blur(logic [PIX_W-1:0] level, bit run_last, bit image_end);
      blur_result_t r;
      r.level     = level;
      r.run_last  = run_last;
      r.image_end = image_end;
      expected_blur_q.push_back(r);
    endfunction

    function void take_beat(logic cmd, logic [PIX_W-1:0] px);
      int unsigned w, h, c, d, l, r, s;
      logic [PIX_W-1:0] top, mid;
      bit last;
      w = eff_w();
      h = eff_h();
      if (cmd == CMD_PIXEL) begin
        if (draining) return;           // pixel during drain is dropped
        c = col_cnt % MAX_WIDTH;
        last = (c + 1 >= w);
        if (row_cnt >= 1) begin
          mid = newer_row[c];
          top = (row_cnt >= 2) ? older_row[c] : mid;
          if (c == 0) begin
            // left border: the first column stands in for its left neighbor
            repeat (3) shift_col(top, mid, px);
          end else begin
            shift_col(top, mid, px);
            push_blur(clamped_mean(win_sum()), !last, 1'b0);
          end
          if (last) begin
            // right border: repeat the last column
            shift_col(win[6], win[7], win[8]);
            push_blur(clamped_mean(win_sum()), 1'b1, 1'b0);
          end
        end
        older_row[c] = newer_row[c];
        newer_row[c] = px;
        if (last) begin
          col_cnt = 0;
          if (row_cnt + 1 >= h) begin
            draining  = 1'b1;
            drain_pos = 0;
          end else begin
            row_cnt = (row_cnt + 1) & 12'hFFF;
          end
        end else begin
          col_cnt = c + 1;
        end
      end else begin
        if (!draining) return;          // drain outside the drain phase
        d = drain_pos % MAX_WIDTH;
        last = (d + 1 >= w);
        l = (d == 0) ? 0 : d - 1;
        r = last ? w - 1 : d + 1;
        if (r > d + 1) r = d;
        // bottom border: last row counted twice
        s = older_row[l] + older_row[d] + older_row[r]
          + 2 * (newer_row[l] + newer_row[d] + newer_row[r]);
        push_blur(clamped_mean(s), 1'b1, last);
        if (last) begin
          draining  = 1'b0;
          row_cnt   = 0;
          col_cnt   = 0;
          drain_pos = 0;
          frames_done++;
        end else begin
          drain_pos = d + 1;
        end
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void check_beat(logic [PIX_W-1:0] level, logic run_last, logic image_end);
      blur_result_t want;
      if (expected_blur_q.size() == 0) begin
        flag($sformatf("unexpected beat: pixel_out=%0d run_last=%0b image_end=%0b",
                       level, run_last, image_end));
        return;
      end
      want = expected_blur_q.pop_front();
      if (level !== want.level)
        flag($sformatf("pixel_out expected %0d actual %0d", want.level, level));
      if (run_last !== want.run_last)
        flag($sformatf("run_last expected %0b actual %0b", want.run_last, run_last));
      if (image_end !== want.image_end)
        flag($sformatf("image_end expected %0b actual %0b", want.image_end, image_end));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 cmd_i;
  logic [PIX_W-1:0]     pixel_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 run_last_o;
  logic                 image_end_o;

  box_blur_3x3_replicate_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .run_last_o  (run_last_o),
    .image_end_o (image_end_o)
  );

  blur_scoreboard   sb;
  int unsigned      beats_taken;    // every accepted input beat, dropped ones too
  int unsigned      work_beats;     // random-phase beats that the unit acts on
  int unsigned      burst_left;
  bit               squeeze_req;    // asks the sink for one long hold-off
  logic [PIX_W-1:0] probe_levels [9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F,
                                         8'hF0, 8'h01, 8'h80, 8'h7F};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Single monitor so that config, input and output beats of one edge are
  // always seen in the same order. The beat count is bumped last: the
  // driver waits on it and then reads up-to-date scoreboard state.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.take_beat(cmd_i, pixel_in_i);
      if (out_valid_o && out_ready_i) sb.check_beat(pixel_out_o, run_last_o, image_end_o);
      if (in_valid_i && in_ready_o) beats_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Output sink: segments of always-ready, random stalls, a sparse periodic
  // pattern and short hold-offs. One long hold-off on request backs the
  // unit up until in_ready_o drops.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned kind, span, period, k;
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        repeat (SQUEEZE_CYCLES) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
      kind   = $urandom_range(0, 9);
      span   = $urandom_range(10, 150);
      period = $urandom_range(2, 4);
      for (k = 0; k < span && !squeeze_req; k++) begin
        @(negedge clk_i);
        if (kind < 4) out_ready_i <= 1'b1;
        else if (kind < 7) out_ready_i <= ($urandom_range(0, 2) != 0);
        else if (kind < 9) out_ready_i <= (k % period == 0);
        else out_ready_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // One input beat. Bursts of random length with random gaps in between;
  // valid stays up across back-to-back beats inside a burst.
  task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] px);
    int unsigned gap, target;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    target = beats_taken + 1;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    pixel_in_i <= px;
    wait (beats_taken == target);
  endtask

  // Stop offering beats and let every outstanding result drain out.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h,
                           input int unsigned lo, input int unsigned hi);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CLAMP_LOW, lo);
    write_reg(CFG_CLAMP_HIGH, hi);
  endtask

  // 0: uniform, 1: black/white only, 2: near white, 3: near black
  function automatic logic [PIX_W-1:0] rand_level(int unsigned mode);
    case (mode)
      1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2:       return 8'hFF - PIX_W'($urandom_range(0, 7));
      3:       return PIX_W'($urandom_range(0, 7));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Feed pixels, then drains, until the scoreboard sees the frame close.
  // The command of each beat follows the predicted position, with a few
  // wrong-phase beats mixed in that the unit must drop. At beat retune_at
  // the frame pauses: width never grows, height is new and the limits never cross.
  task automatic stream_frame(input int unsigned retune_at, input int unsigned mode);
    int unsigned start_frames, n;
    start_frames = sb.frames_done;
    n = 0;
    while (sb.frames_done == start_frames) begin
      if (n == retune_at) begin
        quiesce();
        set_image($urandom_range(0, sb.eff_w()), $urandom_range(0, 8),
                  $urandom_range(0, 80), $urandom_range(150, 255));
      end
      if ($urandom_range(0, 24) == 0)
        send_beat(sb.draining ? CMD_PIXEL : CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
      send_beat(sb.draining ? CMD_DRAIN : CMD_PIXEL, rand_level(mode));
      n++;
    end
    work_beats += n;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w, h, wv, hv, lo, hi, pick;
    bit first_random;
    sb          = new();
    beats_taken = 0;
    work_beats  = 0;
    burst_left  = 0;
    squeeze_req = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_PIXEL;
    pixel_in_i  = '0;
    out_ready_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Smallest image: width and height below the floor clamp to 2x2. A
    // drain before the drain phase and a pixel inside it are both dropped.
    set_image(1, 0, 0, 255);
    send_beat(CMD_DRAIN, 8'h00);
    send_beat(CMD_PIXEL, 8'h00);
    send_beat(CMD_PIXEL, 8'hFF);
    send_beat(CMD_PIXEL, 8'hFF);
    send_beat(CMD_PIXEL, 8'h00);
    send_beat(CMD_PIXEL, 8'hAA);
    send_beat(CMD_DRAIN, 8'h55);
    send_beat(CMD_DRAIN, 8'hFF);

    // 3x3 with the low limit above the high limit
    quiesce();
    set_image(3, 3, 200, 50);
    foreach (probe_levels[i]) send_beat(CMD_PIXEL, probe_levels[i]);
    repeat (3) send_beat(CMD_DRAIN, 8'h00);

    // Register maxima (width and height clamp to their limits). One full
    // 1024-pixel row plus a few pixels, then shrink the frame mid-row: the
    // current column is past the new end, and the current row is the new last one.
    quiesce();
    set_image(2047, 8191, 0, 255);
    repeat (MAX_WIDTH + 6) send_beat(CMD_PIXEL, rand_level(0));
    quiesce();
    set_image(3, 2, 16, 240);
    stream_frame(NO_RETUNE, 0);

    // Random frames, mostly small; the first one runs under the long
    // output hold-off.
    first_random = 1'b1;
    while (work_beats < RANDOM_BEATS) begin
      quiesce();
      pick = $urandom_range(0, 19);
      if (first_random) w = 12;
      else if (pick < 14) w = $urandom_range(2, 8);
      else if (pick < 19) w = $urandom_range(9, 32);
      else w = $urandom_range(33, 96);
      h  = first_random ? 4 : $urandom_range(2, 6);
      wv = (w == 2 && $urandom_range(0, 1) != 0) ? $urandom_range(0, 1) : w;
      hv = (h == 2 && $urandom_range(0, 1) != 0) ? $urandom_range(0, 1) : h;
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        lo = 0;
        hi = 255;
      end else if (pick == 2) begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(0, 255);
      end else begin
        lo = $urandom_range(20, 100);
        hi = $urandom_range(150, 235);
      end
      set_image(wv, hv, lo, hi);
      if (first_random) squeeze_req = 1'b1;
      stream_frame((!first_random && $urandom_range(0, 4) == 0)
                     ? $urandom_range(0, w * h + w) : NO_RETUNE,
                   ($urandom_range(0, 5) > 3) ? $urandom_range(1, 3) : 0);
      first_random = 1'b0;
    end

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: box_blur_3x3_replicate_unit.f
+incdir+rtl
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_queue.sv
rtl/bb3_front.sv
rtl/bb3_back.sv
rtl/box_blur_3x3_replicate_unit.sv
verif/box_blur_3x3_replicate_unit_tb.sv
